[hdl/cellular_automaton_generation_core_macros.svh]
// Assertion helpers shared by the RTL files of the generation core.
// Both forms sample on the rising edge of clk and are switched off during rst.
`ifndef CELLULAR_AUTOMATON_GENERATION_CORE_MACROS_SVH
`define CELLULAR_AUTOMATON_GENERATION_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define CAGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

`define CAGC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`else

`define CAGC_ASSERT(lbl, prop, msg)

`define CAGC_NEVER(lbl, expr, msg)

`endif

`endif

[hdl/cagc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cagc_pkg;

  localparam int IDX_W      = 10;
  localparam int VAL_W      = 2;
  localparam int CELL_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int RAD_W      = 2;
  // Holds the first r old cells of a wrapped pass; r fits in RAD_W bits.
  localparam int SAVE_DEPTH = 4;
  localparam int SAVE_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLORS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LATTICE_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RULE_ENTRIES   = 3'd4;

  typedef enum logic [1:0] {
    ACT_LOAD_RULE = 2'd0,
    ACT_LOAD_CELL = 2'd1,
    ACT_STEP      = 2'd2,
    ACT_READ      = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_VALUE = 2'd2
  } status_t;

  typedef struct packed {
    action_t          action;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    status_t          status;
  } rsp_t;

  // Travels with each cell of a generation pass, read or replayed from a saved copy.
  typedef struct packed {
    logic                  valid;
    logic                  save;
    logic                  sub;
    logic                  emit;
    logic                  last;
    logic [SAVE_IDX_W-1:0] save_idx;
    logic [SAVE_IDX_W-1:0] sub_idx;
  } scan_tag_t;

  typedef struct packed {
    logic we;
    logic last;
  } gen_wr_t;

endpackage

`default_nettype wire

[hdl/cellular_automaton_generation_core.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "cellular_automaton_generation_core_macros.svh"

// Loads and reads: the result item is registered and appears in the cycle after
// the item is accepted. Once its scan runs, a generation reads one cell per cycle
// through the cell memory read port, except the saved cells a wrapped pass replays;
// busy is high until its result appears. Results cannot be stalled.
// Synchronous reset restores the register defaults; rule and cell memories keep
// their contents and are undefined until written.
module cellular_automaton_generation_core #(
  parameter int LATTICE_CELLS = 64,
  parameter int RULE_DEPTH    = 1024,
  parameter int MAX_COLORS    = 4,
  parameter int MAX_RADIUS    = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  cagc_pkg::cmd_t                      cmd,
  output logic                                busy,
  output logic                                done,
  output cagc_pkg::rsp_t                      rsp,
  input  logic                                cfg_we,
  input  logic [cagc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cagc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import cagc_pkg::*;

  localparam int CA_W = $clog2(LATTICE_CELLS);
  localparam int RA_W = $clog2(RULE_DEPTH);
  localparam int K_W  = $clog2(MAX_COLORS + 1);
  localparam int L_W  = $clog2(LATTICE_CELLS + 1);
  localparam int E_W  = $clog2(RULE_DEPTH + 1);

  localparam logic [K_W-1:0]   K_RST = K_W'(2);
  localparam logic [RAD_W-1:0] R_RST = RAD_W'((MAX_RADIUS < 1) ? 0 : 1);
  localparam logic [L_W-1:0]   L_RST = L_W'((LATTICE_CELLS < 64) ? LATTICE_CELLS : 64);
  localparam logic [E_W-1:0]   E_RST = E_W'((RULE_DEPTH < 8) ? RULE_DEPTH : 8);

  typedef enum logic {
    ST_IDLE,
    ST_GEN
  } state_t;

  // Registers hold the saturated values so no clamp sits on the item path.
  logic [K_W-1:0]   k_eff;
  logic [RAD_W-1:0] r_eff;
  logic             wrap;
  logic [L_W-1:0]   len_eff;
  logic [E_W-1:0]   ent_eff;

  logic [K_W-1:0]   k_wr;
  logic [RAD_W-1:0] r_wr;
  logic [L_W-1:0]   len_wr;
  logic [E_W-1:0]   ent_wr;
  int               v_k;
  int               v_r;
  int               v_len;
  int               v_ent;

  state_t  state;
  status_t status_q;
  logic    rd_ok_q;
  status_t chk;
  logic    acc;

  logic                cell_we;
  logic [CA_W-1:0]     cell_waddr;
  logic [CELL_W-1:0]   cell_wdata;
  logic                cell_re;
  logic [CA_W-1:0]     cell_raddr;
  logic [CELL_W-1:0]   cell_rdata;

  logic                rule_we;
  logic                rule_re;
  logic [RA_W-1:0]     rule_raddr;
  logic [CELL_W-1:0]   rule_rdata;

  logic                scan_rd_en;
  logic [CA_W-1:0]     scan_addr;
  scan_tag_t           scan_tag;
  logic [CA_W-1:0]     scan_idx;

  gen_wr_t             nb_wr;
  logic [CA_W-1:0]     nb_addr;
  logic [CELL_W-1:0]   nb_data;

  always_comb begin
    v_k   = int'(cfg_wdata[2:0]);
    v_r   = int'(cfg_wdata[1:0]);
    v_len = int'(cfg_wdata[6:0]);
    v_ent = int'(cfg_wdata[10:0]);
    k_wr   = K_W'((v_k < 2) ? 2 : ((v_k > MAX_COLORS) ? MAX_COLORS : v_k));
    r_wr   = RAD_W'((v_r > MAX_RADIUS) ? MAX_RADIUS : v_r);
    len_wr = L_W'((v_len < 1) ? 1 : ((v_len > LATTICE_CELLS) ? LATTICE_CELLS : v_len));
    ent_wr = E_W'((v_ent < 1) ? 1 : ((v_ent > RULE_DEPTH) ? RULE_DEPTH : v_ent));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_eff   <= K_RST;
      r_eff   <= R_RST;
      wrap    <= 1'b1;
      len_eff <= L_RST;
      ent_eff <= E_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_COLORS:     k_eff   <= k_wr;
        REG_RADIUS:         r_eff   <= r_wr;
        REG_WRAP_MODE:      wrap    <= cfg_wdata[0];
        REG_LATTICE_LENGTH: len_eff <= len_wr;
        REG_RULE_ENTRIES:   ent_eff <= ent_wr;
        default: ;
      endcase
    end
  end

  assign busy = (state == ST_GEN);
  assign acc  = start && !busy;

  // The index is checked before the value.
  always_comb begin
    case (cmd.action)
      ACT_LOAD_RULE: begin
        if (int'(cmd.index) >= int'(ent_eff)) begin
          chk = STAT_RANGE;
        end else if (int'(cmd.value) >= int'(k_eff)) begin
          chk = STAT_VALUE;
        end else begin
          chk = STAT_OK;
        end
      end
      ACT_LOAD_CELL: begin
        if (int'(cmd.index) >= int'(len_eff)) begin
          chk = STAT_RANGE;
        end else if (int'(cmd.value) >= int'(k_eff)) begin
          chk = STAT_VALUE;
        end else begin
          chk = STAT_OK;
        end
      end
      ACT_READ: begin
        chk = (int'(cmd.index) >= int'(len_eff)) ? STAT_RANGE : STAT_OK;
      end
      default: begin
        chk = STAT_OK;
      end
    endcase
  end

  always_comb begin
    rule_we    = acc && (cmd.action == ACT_LOAD_RULE) && (chk == STAT_OK);
    cell_we    = (acc && (cmd.action == ACT_LOAD_CELL) && (chk == STAT_OK)) || nb_wr.we;
    cell_waddr = nb_wr.we ? nb_addr : CA_W'(cmd.index);
    cell_wdata = nb_wr.we ? nb_data : cmd.value;
    cell_re    = (acc && (cmd.action == ACT_READ) && (chk == STAT_OK)) || scan_rd_en;
    cell_raddr = scan_rd_en ? scan_addr : CA_W'(cmd.index);

    rsp.read_value = rd_ok_q ? cell_rdata : '0;
    rsp.status     = status_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      rd_ok_q  <= 1'b0;
      status_q <= STAT_OK;
    end else begin
      done    <= 1'b0;
      rd_ok_q <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (acc) begin
            if (cmd.action == ACT_STEP) begin
              state <= ST_GEN;
            end else begin
              done     <= 1'b1;
              status_q <= chk;
              rd_ok_q  <= (cmd.action == ACT_READ) && (chk == STAT_OK);
            end
          end
        end
        ST_GEN: begin
          if (nb_wr.we && nb_wr.last) begin
            done     <= 1'b1;
            status_q <= STAT_OK;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  cagc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (RULE_DEPTH)
  ) u_rule_ram (
    .clk   (clk),
    .we    (rule_we),
    .waddr (RA_W'(cmd.index)),
    .wdata (cmd.value),
    .re    (rule_re),
    .raddr (rule_raddr),
    .rdata (rule_rdata)
  );

  cagc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (LATTICE_CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  cagc_scan #(
    .LATTICE_CELLS (LATTICE_CELLS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .go       (acc && (cmd.action == ACT_STEP)),
    .len_eff  (len_eff),
    .r_eff    (r_eff),
    .wrap     (wrap),
    .rd_en    (scan_rd_en),
    .rd_addr  (scan_addr),
    .tag      (scan_tag),
    .cell_idx (scan_idx)
  );

  cagc_nbhd #(
    .LATTICE_CELLS (LATTICE_CELLS),
    .RULE_DEPTH    (RULE_DEPTH),
    .MAX_COLORS    (MAX_COLORS),
    .MAX_RADIUS    (MAX_RADIUS)
  ) u_nbhd (
    .clk        (clk),
    .rst        (rst),
    .r_eff      (r_eff),
    .k_eff      (k_eff),
    .ent_eff    (ent_eff),
    .tag        (scan_tag),
    .tag_idx    (scan_idx),
    .cell_rdata (cell_rdata),
    .rule_re    (rule_re),
    .rule_raddr (rule_raddr),
    .rule_rdata (rule_rdata),
    .wr         (nb_wr),
    .wr_addr    (nb_addr),
    .wr_data    (nb_data)
  );

  `CAGC_NEVER(a_done_not_busy, done && busy, "result item shown while a generation runs")
  `CAGC_ASSERT(a_short_done, (start && !busy && (cmd.action != ACT_STEP)) |=> done, "load or read item gave no result")
  `CAGC_ASSERT(a_gen_busy, (start && !busy && (cmd.action == ACT_STEP)) |=> busy, "generation did not start")
  `CAGC_NEVER(a_gen_wr_idle, nb_wr.we && !busy, "generation write outside a generation")

endmodule

`default_nettype wire

[hdl/cagc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module cagc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/cagc_scan.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "cellular_automaton_generation_core_macros.svh"

module cagc_scan #(
  parameter int LATTICE_CELLS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   go,
  input  logic [$clog2(LATTICE_CELLS+1)-1:0]     len_eff,
  input  logic [cagc_pkg::RAD_W-1:0]             r_eff,
  input  logic                                   wrap,
  output logic                                   rd_en,
  output logic [$clog2(LATTICE_CELLS)-1:0]       rd_addr,
  output cagc_pkg::scan_tag_t                    tag,
  output logic [$clog2(LATTICE_CELLS)-1:0]       cell_idx
);

  import cagc_pkg::*;

  localparam int CA_W = $clog2(LATTICE_CELLS);
  localparam int L_W  = $clog2(LATTICE_CELLS + 1);
  localparam int C_W  = L_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRE,
    S_RUN
  } state_t;

  state_t          state;
  logic [CA_W-1:0] pos;
  logic [C_W-1:0]  cnt;
  logic [RAD_W-1:0] pre_cnt;

  logic [C_W-1:0]  r_c;
  logic [C_W-1:0]  r2_c;
  logic [C_W-1:0]  len_c;
  logic [C_W-1:0]  total_m1;
  logic [CA_W-1:0] len_m1;
  logic            run;
  logic            s_sub;

  // The stream walks positions -r .. len-1+r once each. In wrap mode the
  // last r entries repeat the first r old cells, which are replayed from
  // saved copies because those cells have been rewritten by then.
  always_comb begin
    r_c      = C_W'(r_eff);
    r2_c     = C_W'(r_eff) << 1;
    len_c    = C_W'(len_eff);
    total_m1 = len_c + r2_c - C_W'(1);
    len_m1   = CA_W'(len_eff - L_W'(1));
    run      = (state == S_RUN);
    s_sub    = run && wrap && (cnt >= len_c + r_c) && (cnt >= r2_c);

    tag.valid    = run;
    tag.save     = run && (cnt >= r_c) && (cnt < r2_c);
    tag.save_idx = SAVE_IDX_W'(cnt - r_c);
    tag.sub      = s_sub;
    tag.sub_idx  = SAVE_IDX_W'(cnt - r_c - len_c);
    tag.emit     = run && (cnt >= r2_c);
    tag.last     = run && (cnt == total_m1);

    cell_idx = CA_W'(cnt - r2_c);
    rd_en    = run && !s_sub;
    rd_addr  = pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pos     <= '0;
      cnt     <= '0;
      pre_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (go) begin
            pos     <= '0;
            cnt     <= '0;
            pre_cnt <= '0;
            state   <= (r_eff == '0) ? S_RUN : S_PRE;
          end
        end
        S_PRE: begin
          // Wrap mode starts at (-r) mod len, reached by r backward steps.
          if (wrap) begin
            pos <= (pos == '0) ? len_m1 : pos - CA_W'(1);
          end
          pre_cnt <= pre_cnt + RAD_W'(1);
          if (pre_cnt == r_eff - RAD_W'(1)) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          cnt <= cnt + C_W'(1);
          if (wrap) begin
            pos <= (pos == len_m1) ? '0 : pos + CA_W'(1);
          end else if ((cnt >= r_c) && (pos != len_m1)) begin
            pos <= pos + CA_W'(1);
          end
          if (tag.last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CAGC_NEVER(a_save_sub_excl, tag.save && tag.sub, "scan saves and replays in one cycle")
  `CAGC_NEVER(a_sub_needs_wrap, tag.sub && !wrap, "scan replays a saved cell in clamp mode")
  `CAGC_NEVER(a_emit_in_len, tag.emit && (L_W'(cell_idx) >= len_eff), "cell index beyond length")

endmodule

`default_nettype wire

[hdl/cagc_nbhd.sv]
`timescale 1ns / 1ps
`default_nettype none

module cagc_nbhd #(
  parameter int LATTICE_CELLS = 64,
  parameter int RULE_DEPTH    = 1024,
  parameter int MAX_COLORS    = 4,
  parameter int MAX_RADIUS    = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [cagc_pkg::RAD_W-1:0]          r_eff,
  input  logic [$clog2(MAX_COLORS+1)-1:0]     k_eff,
  input  logic [$clog2(RULE_DEPTH+1)-1:0]     ent_eff,
  input  cagc_pkg::scan_tag_t                 tag,
  input  logic [$clog2(LATTICE_CELLS)-1:0]    tag_idx,
  input  logic [cagc_pkg::CELL_W-1:0]         cell_rdata,
  output logic                                rule_re,
  output logic [$clog2(RULE_DEPTH)-1:0]       rule_raddr,
  input  logic [cagc_pkg::CELL_W-1:0]         rule_rdata,
  output cagc_pkg::gen_wr_t                   wr,
  output logic [$clog2(LATTICE_CELLS)-1:0]    wr_addr,
  output logic [cagc_pkg::CELL_W-1:0]         wr_data
);

  import cagc_pkg::*;

  localparam int CA_W  = $clog2(LATTICE_CELLS);
  localparam int RA_W  = $clog2(RULE_DEPTH);
  localparam int E_W   = $clog2(RULE_DEPTH + 1);
  localparam int WIN   = 2 * MAX_RADIUS + 1;
  localparam int DIG_W = (MAX_COLORS > 4) ? 3 : 2;
  localparam int NUM_W = WIN * DIG_W;
  localparam int CMP_W = (NUM_W > E_W) ? NUM_W : E_W;

  scan_tag_t       tag_q;
  logic [CA_W-1:0] idx_q;

  logic [CELL_W-1:0] win   [WIN];
  logic [CELL_W-1:0] saved [SAVE_DEPTH];
  logic [CELL_W-1:0] din;

  logic             s1_emit;
  logic             s1_last;
  logic [CA_W-1:0]  s1_idx;

  logic             h_valid;
  logic             h_last;
  logic [CA_W-1:0]  h_idx;
  logic [NUM_W-1:0] h_num;
  logic [NUM_W-1:0] acc;

  logic             r_valid;
  logic             r_last;
  logic             r_oor;
  logic [CA_W-1:0]  r_idx;
  logic [CMP_W-1:0] diff;
  logic             oor;

  // win[0] is the newest cell, the rightmost neighbor and least
  // significant digit; win[2r] is the leftmost neighbor.
  always_comb begin
    din = tag_q.sub ? saved[tag_q.sub_idx] : cell_rdata;
    acc = '0;
    for (int j = WIN - 1; j >= 0; j--) begin
      if (j <= 2 * int'(r_eff)) begin
        acc = NUM_W'(acc * k_eff) + NUM_W'(win[j]);
      end
    end
  end

  always_comb begin
    oor        = CMP_W'(h_num) >= CMP_W'(ent_eff);
    diff       = CMP_W'(ent_eff) - CMP_W'(h_num) - CMP_W'(1);
    rule_re    = h_valid;
    rule_raddr = diff[RA_W-1:0];
    wr.we      = r_valid;
    wr.last    = r_last;
    wr_addr    = r_idx;
    wr_data    = r_oor ? '0 : rule_rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q   <= '0;
      s1_emit <= 1'b0;
      h_valid <= 1'b0;
      r_valid <= 1'b0;
    end else begin
      tag_q   <= tag;
      s1_emit <= tag_q.valid && tag_q.emit;
      h_valid <= s1_emit;
      r_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    idx_q <= tag_idx;
    if (tag_q.valid) begin
      win[0] <= din;
      for (int j = 1; j < WIN; j++) begin
        win[j] <= win[j-1];
      end
      if (tag_q.save) begin
        saved[tag_q.save_idx] <= cell_rdata;
      end
    end
    s1_last <= tag_q.last;
    s1_idx  <= idx_q;
    h_num   <= acc;
    h_last  <= s1_last;
    h_idx   <= s1_idx;
    r_oor   <= oor;
    r_last  <= h_last;
    r_idx   <= h_idx;
  end

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import cagc_pkg::*;

  localparam int LATTICE_CELLS = 64;
  localparam int RULE_DEPTH    = 1024;
  localparam int MAX_COLORS    = 4;
  localparam int MAX_RADIUS    = 2;

  // Tracks the automaton state and holds the responses still to come.
  class automaton_scoreboard;
    logic [2:0]  colors_reg;
    logic [1:0]  radius_reg;
    logic        wrap_reg;
    logic [6:0]  length_reg;
    logic [10:0] entries_reg;
    logic [1:0]  rules [RULE_DEPTH];
    logic [1:0]  lattice [LATTICE_CELLS];
    rsp_t        expected_rsp [$];
    int          errors;

    function new();
      colors_reg  = 3'd2;
      radius_reg  = 2'd1;
      wrap_reg    = 1'b1;
      length_reg  = 7'd64;
      entries_reg = 11'd8;
      errors      = 0;
      foreach (rules[i]) rules[i] = 2'd0;
      foreach (lattice[i]) lattice[i] = 2'd0;
    endfunction

    function int saturate(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int colors();
      return saturate(int'(colors_reg), 2, MAX_COLORS);
    endfunction

    function int reach();
      return saturate(int'(radius_reg), 0, MAX_RADIUS);
    endfunction

    function int cells_in_use();
      return saturate(int'(length_reg), 1, LATTICE_CELLS);
    endfunction

    function int rule_count();
      return saturate(int'(entries_reg), 1, RULE_DEPTH);
    endfunction

    function int waiting();
      return expected_rsp.size();
    endfunction

    function void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_NUM_COLORS:     colors_reg  = data[2:0];
        REG_RADIUS:         radius_reg  = data[1:0];
        REG_WRAP_MODE:      wrap_reg    = data[0];
        REG_LATTICE_LENGTH: length_reg  = data[6:0];
        REG_RULE_ENTRIES:   entries_reg = data;
        default: ;
      endcase
    endfunction

    // All cells in use update at once from the old lattice.
    function void advance_generation();
      int k;
      int r;
      int len;
      int ent;
      int p;
      longint num;
      logic [1:0] fresh [LATTICE_CELLS];
      k   = colors();
      r   = reach();
      len = cells_in_use();
      ent = rule_count();
      for (int i = 0; i < len; i++) begin
        num = 0;
        for (int d = 0; d <= 2 * r; d++) begin
          p = i + d - r;
          if (wrap_reg) begin
            p = p % len;
            if (p < 0) p += len;
          end else if (p < 0) begin
            p = 0;
          end else if (p > len - 1) begin
            p = len - 1;
          end
          num = num * k + longint'(lattice[p]);
        end
        fresh[i] = (num < ent) ? rules[ent - 1 - num] : 2'd0;
      end
      for (int i = 0; i < len; i++) lattice[i] = fresh[i];
    endfunction

    function void take_command(cmd_t c);
      rsp_t r;
      r.read_value = '0;
      r.status     = STAT_OK;
      case (c.action)
        ACT_LOAD_RULE: begin
          if (int'(c.index) >= rule_count()) r.status = STAT_RANGE;
          else if (int'(c.value) >= colors()) r.status = STAT_VALUE;
          else rules[c.index] = c.value;
        end
        ACT_LOAD_CELL: begin
          if (int'(c.index) >= cells_in_use()) r.status = STAT_RANGE;
          else if (int'(c.value) >= colors()) r.status = STAT_VALUE;
          else lattice[c.index] = c.value;
        end
        ACT_STEP: advance_generation();
        default: begin
          if (int'(c.index) >= cells_in_use()) r.status = STAT_RANGE;
          else r.read_value = lattice[c.index];
        end
      endcase
      expected_rsp.push_back(r);
    endfunction

    task report(string what);
      if (errors < 100) $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        report("response with no command outstanding");
      end else begin
        want = expected_rsp.pop_front();
        if (got.read_value !== want.read_value)
          report($sformatf("read_value %0d, expected %0d", got.read_value, want.read_value));
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic done;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  automaton_scoreboard sb;
  bit rule_loaded [RULE_DEPTH];
  bit idle_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cellular_automaton_generation_core DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always @(posedge clk) begin
    if (!rst && done) sb.check_response(rsp);
  end

  function automatic cmd_t make_cmd(action_t a, int idx, int val);
    cmd_t c;
    c.action = a;
    c.index  = idx[IDX_W-1:0];
    c.value  = val[VAL_W-1:0];
    return c;
  endfunction

  task automatic send_item(input cmd_t c);
    @(negedge clk);
    start = 1'b1;
    cmd   = c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.take_command(c);
  endtask

  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (sb.waiting() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data[CFG_DATA_W-1:0];
    sb.apply_setting(idx, data[CFG_DATA_W-1:0]);
  endtask

  task automatic configure(input int k, input int r, input int wrap, input int len,
                           input int ent);
    drain_results();
    repeat (2) @(negedge clk);
    write_reg(REG_NUM_COLORS, k);
    write_reg(REG_RADIUS, r);
    write_reg(REG_WRAP_MODE, wrap);
    write_reg(REG_LATTICE_LENGTH, len);
    write_reg(REG_RULE_ENTRIES, ent);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // A generation must never touch a rule entry or cell that was never loaded.
  task automatic prime_state(input bit fresh_cells);
    for (int i = 0; i < sb.rule_count(); i++) begin
      if (!rule_loaded[i]) begin
        send_item(make_cmd(ACT_LOAD_RULE, i, $urandom_range(0, sb.colors() - 1)));
        rule_loaded[i] = 1'b1;
      end
    end
    if (fresh_cells) begin
      for (int i = 0; i < sb.cells_in_use(); i++)
        send_item(make_cmd(ACT_LOAD_CELL, i, $urandom_range(0, sb.colors() - 1)));
    end
  endtask

  task automatic random_items(input int count);
    int sel;
    int idx;
    action_t a;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) a = ACT_LOAD_RULE;
      else if (sel < 55) a = ACT_LOAD_CELL;
      else if (sel < 70) a = ACT_STEP;
      else a = ACT_READ;
      if ($urandom_range(0, 3) == 0) idx = $urandom_range(0, (1 << IDX_W) - 1);
      else if (a == ACT_LOAD_RULE) idx = $urandom_range(0, sb.rule_count() - 1);
      else idx = $urandom_range(0, sb.cells_in_use() - 1);
      send_item(make_cmd(a, idx, $urandom_range(0, 3)));
      if (idle_on) begin
        if (n % 97 == 96) drain_results();
        else if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 4));
      end
    end
  endtask

  initial begin
    sb = new();
    idle_on = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default settings: two colors, radius one, wrapped, 64 cells, 8 rule entries.
    prime_state(1'b1);
    send_item(make_cmd(ACT_LOAD_RULE, 1023, 3));
    send_item(make_cmd(ACT_LOAD_RULE, 0, 3));
    send_item(make_cmd(ACT_LOAD_RULE, 8, 0));
    send_item(make_cmd(ACT_LOAD_RULE, 7, 1));
    send_item(make_cmd(ACT_LOAD_CELL, 63, 1));
    send_item(make_cmd(ACT_LOAD_CELL, 64, 0));
    send_item(make_cmd(ACT_LOAD_CELL, 1023, 3));
    send_item(make_cmd(ACT_LOAD_CELL, 0, 2));
    send_item(make_cmd(ACT_READ, 0, 0));
    send_item(make_cmd(ACT_READ, 63, 3));
    send_item(make_cmd(ACT_READ, 64, 0));
    send_item(make_cmd(ACT_READ, 1023, 3));
    send_item(make_cmd(ACT_STEP, 0, 0));
    send_item(make_cmd(ACT_READ, 0, 0));
    send_item(make_cmd(ACT_STEP, 1023, 3));
    send_item(make_cmd(ACT_READ, 63, 0));
    send_item(make_cmd(ACT_READ, 62, 0));
    random_items(100);

    configure(3, 1, 0, 20, 27);
    prime_state(1'b1);
    random_items(100);

    configure(2, 2, 1, 3, 32);
    prime_state(1'b1);
    random_items(100);

    // Radius not smaller than the lattice: neighbors wrap onto the same cell.
    configure(2, 1, 1, 1, 8);
    prime_state(1'b1);
    random_items(80);

    // A short table: the larger neighborhoods fall past its end.
    configure(4, 2, 0, 64, 256);
    prime_state(1'b1);
    random_items(120);

    // Fewer colors over the old lattice pushes some neighborhoods past the table.
    configure(2, 1, 0, 64, 8);
    prime_state(1'b0);
    random_items(100);

    configure(2, 0, 1, 64, 2);
    prime_state(1'b1);
    random_items(100);

    configure(4, 2, 1, 5, 256);
    prime_state(1'b1);
    random_items(100);

    configure(4, 1, 1, 64, 64);
    prime_state(1'b1);
    idle_on = 1'b0;
    random_items(140);

    drain_results();
    repeat (100) @(negedge clk);
    if (sb.errors == 0) begin
      $display("[cellular_automaton_generation_core] OK");
    end else begin
      $display("[cellular_automaton_generation_core] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[cellular_automaton_generation_core] ERROR");
    $finish;
  end

endmodule
